// ===== rtl/core/hbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared constants and types for the bit-serial hypotenuse block.
// ----------------------------------------------------------------------------
package hbs_pkg;

   localparam int HBS_LEG_WIDTH  = 16;
   localparam int HBS_ITER_WIDTH = 5;
   localparam int HBS_STEP_WIDTH = 8;
   localparam int HBS_SUM_LIMIT  = 64;

   localparam logic [HBS_ITER_WIDTH-1:0] HBS_ITER_RESET = 5'd10;
   localparam logic [HBS_STEP_WIDTH-1:0] HBS_START_STEP = 8'd26;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQA,
      ST_SQA_WAIT,
      ST_SQB,
      ST_SQB_WAIT,
      ST_ROOT,
      ST_ROOT_WAIT,
      ST_STEP,
      ST_STEP_WAIT,
      ST_SCALE,
      ST_SCALE_WAIT,
      ST_ITER,
      ST_ITER_WAIT,
      ST_FIN
   } hbs_state_type;

endpackage

// ===== rtl/core/hbs_mul.sv =====
// ----------------------------------------------------------------------------
// hbs_mul
// Shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module hbs_mul
   import hbs_pkg::*;
#(
   parameter int WIDTH = HBS_LEG_WIDTH + 2
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [WIDTH-1:0]   multiplicand,
   input  logic [WIDTH-1:0]   multiplier,
   output logic               done,
   output logic [2*WIDTH-1:0] product
);

   localparam int CNT_WIDTH = $clog2(WIDTH + 1);

   logic [WIDTH-1:0]     mcand_ff;
   logic [2*WIDTH-1:0]   prod_ff;
   logic [2*WIDTH-1:0]   prod_in;
   logic [WIDTH:0]       partial;
   logic [CNT_WIDTH-1:0] count_ff;
   logic                 busy_ff;
   logic                 done_ff;

   always_comb begin
      partial = {1'b0, prod_ff[2*WIDTH-1:WIDTH]} + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
      prod_in = {partial, prod_ff[WIDTH-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_WIDTH'(WIDTH);
         end else if (busy_ff) begin
            count_ff <= count_ff - CNT_WIDTH'(1);
            if (count_ff == CNT_WIDTH'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff <= multiplicand;
         prod_ff  <= {WIDTH'(0), multiplier};
      end else if (busy_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

// ===== rtl/core/hbs_div.sv =====
// ----------------------------------------------------------------------------
// hbs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hbs_div
   import hbs_pkg::*;
#(
   parameter int DIVIDEND_WIDTH = 2 * HBS_LEG_WIDTH + 1,
   parameter int DIVISOR_WIDTH  = HBS_LEG_WIDTH + 2
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DIVIDEND_WIDTH-1:0] dividend,
   input  logic [DIVISOR_WIDTH-1:0]  divisor,
   output logic                      done,
   output logic [DIVIDEND_WIDTH-1:0] quotient
);

   localparam int CNT_WIDTH = $clog2(DIVIDEND_WIDTH + 1);

   logic [DIVISOR_WIDTH-1:0]  divisor_ff;
   logic [DIVISOR_WIDTH-1:0]  rem_ff;
   logic [DIVISOR_WIDTH-1:0]  rem_in;
   logic [DIVIDEND_WIDTH-1:0] quo_ff;
   logic [DIVIDEND_WIDTH-1:0] quo_in;
   logic [DIVISOR_WIDTH:0]    trial;
   logic [DIVISOR_WIDTH+1:0]  diff;
   logic                      take;
   logic [CNT_WIDTH-1:0]      count_ff;
   logic                      busy_ff;
   logic                      done_ff;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIVIDEND_WIDTH-1]};
      diff   = {1'b0, trial} - {2'b00, divisor_ff};
      take   = ~diff[DIVISOR_WIDTH+1];
      rem_in = take ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
      quo_in = {quo_ff[DIVIDEND_WIDTH-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_WIDTH'(DIVIDEND_WIDTH);
         end else if (busy_ff) begin
            count_ff <= count_ff - CNT_WIDTH'(1);
            if (count_ff == CNT_WIDTH'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         divisor_ff <= divisor;
         rem_ff     <= '0;
         quo_ff     <= dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/hbs_sqrt.sv =====
// ----------------------------------------------------------------------------
// hbs_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module hbs_sqrt
   import hbs_pkg::*;
#(
   parameter int ROOT_WIDTH = HBS_LEG_WIDTH + 1
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [2*ROOT_WIDTH-1:0] radicand,
   output logic                    done,
   output logic [ROOT_WIDTH-1:0]   root
);

   localparam int CNT_WIDTH = $clog2(ROOT_WIDTH + 1);

   logic [2*ROOT_WIDTH-1:0] rad_ff;
   logic [2*ROOT_WIDTH-1:0] rad_in;
   logic [ROOT_WIDTH:0]     rem_ff;
   logic [ROOT_WIDTH:0]     rem_in;
   logic [ROOT_WIDTH-1:0]   root_ff;
   logic [ROOT_WIDTH-1:0]   root_in;
   logic [ROOT_WIDTH+2:0]   trial_rem;
   logic [ROOT_WIDTH+2:0]   trial_sub;
   logic [ROOT_WIDTH+3:0]   diff;
   logic                    take;
   logic [CNT_WIDTH-1:0]    count_ff;
   logic                    busy_ff;
   logic                    done_ff;

   always_comb begin
      trial_rem = {rem_ff, rad_ff[2*ROOT_WIDTH-1 -: 2]};
      trial_sub = {1'b0, root_ff, 2'b01};
      diff      = {1'b0, trial_rem} - {1'b0, trial_sub};
      take      = ~diff[ROOT_WIDTH+3];
      rem_in    = take ? diff[ROOT_WIDTH:0] : trial_rem[ROOT_WIDTH:0];
      root_in   = {root_ff[ROOT_WIDTH-2:0], take};
      rad_in    = {rad_ff[2*ROOT_WIDTH-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_WIDTH'(ROOT_WIDTH);
         end else if (busy_ff) begin
            count_ff <= count_ff - CNT_WIDTH'(1);
            if (count_ff == CNT_WIDTH'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== rtl/core/hypotenuse_babylonian_sqrt.sv =====
// ----------------------------------------------------------------------------
// hypotenuse_babylonian_sqrt
// Hypotenuse of two unsigned fixed-point legs by Babylonian square root.
//
// The req channel carries one pair of legs per transfer; the rsp channel
// returns one saturated hypotenuse per pair, in order. csr_wr_en with
// csr_wr_data sets the number of refinement steps N (reset value 10);
// write it only while the block is idle.
// Multiplies, divides and the square root run on three bit-serial units:
// a shift-add multiplier (squares and start estimate scaling), an integer
// square root for the start search, and a restoring divider, one bit per
// cycle each. Each divider step walks all 2*L + 1 bits of the sum for leg
// width L below 32. A new pair is taken only while idle, the cycle after
// the previous result is loaded into the output register. A stalled result
// holds in the output register; a further finished result waits in the
// core, which takes no new pair meanwhile. Reset clears the handshake state
// and restores N to 10.
// ----------------------------------------------------------------------------
module hypotenuse_babylonian_sqrt
   import hbs_pkg::*;
#(
   parameter int LEG_WIDTH = HBS_LEG_WIDTH
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [LEG_WIDTH-1:0]      req_leg_a,
   input  logic [LEG_WIDTH-1:0]      req_leg_b,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [LEG_WIDTH:0]        rsp_hypotenuse,
   input  logic                      csr_wr_en,
   input  logic [HBS_ITER_WIDTH-1:0] csr_wr_data
);

   localparam int FULL_WIDTH = 2 * LEG_WIDTH + 1;
   localparam int SUM_WIDTH  = (FULL_WIDTH > HBS_SUM_LIMIT) ? HBS_SUM_LIMIT : FULL_WIDTH;
   localparam int ROOT_WIDTH = (SUM_WIDTH + 1) / 2;
   localparam int EST_WIDTH  = ROOT_WIDTH + 1;
   localparam int OUT_WIDTH  = LEG_WIDTH + 1;
   localparam int CMP_WIDTH  = (EST_WIDTH > OUT_WIDTH) ? EST_WIDTH : OUT_WIDTH;
   localparam logic [OUT_WIDTH-1:0] OUT_MAX = '1;

   hbs_state_type             state_ff;
   hbs_state_type             state_in;
   logic [HBS_ITER_WIDTH-1:0] iter_count_ff;
   logic [HBS_ITER_WIDTH-1:0] iter_ff;
   logic [HBS_ITER_WIDTH-1:0] iter_in;
   logic [LEG_WIDTH-1:0]      leg_a_ff;
   logic [LEG_WIDTH-1:0]      leg_b_ff;
   logic [SUM_WIDTH-1:0]      sum_ff;
   logic [SUM_WIDTH-1:0]      sum_in;
   logic [ROOT_WIDTH-1:0]     root_ff;
   logic [ROOT_WIDTH-1:0]     root_in;
   logic [EST_WIDTH-1:0]      est_ff;
   logic [EST_WIDTH-1:0]      est_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [OUT_WIDTH-1:0]      rsp_hyp_ff;
   logic                      rsp_load;
   logic                      req_take;

   logic [FULL_WIDTH-1:0]     sum_full;
   logic [SUM_WIDTH-1:0]      sum_sat;
   logic [EST_WIDTH:0]        avg;
   logic [CMP_WIDTH-1:0]      est_cmp;
   logic [OUT_WIDTH-1:0]      hyp_sat;

   logic                      mul_start;
   logic [EST_WIDTH-1:0]      mul_mcand;
   logic [EST_WIDTH-1:0]      mul_mplier;
   logic                      mul_done;
   logic [2*EST_WIDTH-1:0]    mul_product;
   logic                      div_start;
   logic [SUM_WIDTH-1:0]      div_dividend;
   logic [EST_WIDTH-1:0]      div_divisor;
   logic                      div_done;
   logic [SUM_WIDTH-1:0]      div_quotient;
   logic                      sqrt_start;
   logic                      sqrt_done;
   logic [ROOT_WIDTH-1:0]     sqrt_root;

   hbs_mul #(
      .WIDTH(EST_WIDTH)
   ) u_mul (
      .clock       (clock),
      .reset       (reset),
      .start       (mul_start),
      .multiplicand(mul_mcand),
      .multiplier  (mul_mplier),
      .done        (mul_done),
      .product     (mul_product)
   );

   hbs_div #(
      .DIVIDEND_WIDTH(SUM_WIDTH),
      .DIVISOR_WIDTH (EST_WIDTH)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_quotient)
   );

   hbs_sqrt #(
      .ROOT_WIDTH(ROOT_WIDTH)
   ) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .radicand((2*ROOT_WIDTH)'(sum_ff)),
      .done    (sqrt_done),
      .root    (sqrt_root)
   );

   // datapath helpers
   always_comb begin
      sum_full = FULL_WIDTH'(sum_ff) + FULL_WIDTH'(mul_product[2*LEG_WIDTH-1:0]);
      if ((FULL_WIDTH > SUM_WIDTH) && sum_full[FULL_WIDTH-1]) begin
         sum_sat = '1;
      end else begin
         sum_sat = sum_full[SUM_WIDTH-1:0];
      end
      avg     = {1'b0, est_ff} + {1'b0, div_quotient[EST_WIDTH-1:0]};
      est_cmp = CMP_WIDTH'(est_ff);
      if (est_cmp > CMP_WIDTH'(OUT_MAX)) begin
         hyp_sat = OUT_MAX;
      end else begin
         hyp_sat = est_cmp[OUT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         iter_count_ff <= HBS_ITER_RESET;
         iter_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            iter_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         leg_a_ff <= req_leg_a;
         leg_b_ff <= req_leg_b;
      end
      sum_ff  <= sum_in;
      root_ff <= root_in;
      est_ff  <= est_in;
      if (rsp_load) begin
         rsp_hyp_ff <= hyp_sat;
      end
   end

   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      sum_in       = sum_ff;
      root_in      = root_ff;
      est_in       = est_ff;
      req_take     = 1'b0;
      rsp_load     = 1'b0;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      sqrt_start   = 1'b0;
      mul_mcand    = EST_WIDTH'(leg_a_ff);
      mul_mplier   = EST_WIDTH'(leg_a_ff);
      div_dividend = sum_ff;
      div_divisor  = est_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_take = 1'b1;
               state_in = ST_SQA;
            end
         end
         ST_SQA: begin
            mul_start = 1'b1;
            state_in  = ST_SQA_WAIT;
         end
         ST_SQA_WAIT: begin
            if (mul_done) begin
               sum_in   = SUM_WIDTH'(mul_product[2*LEG_WIDTH-1:0]);
               state_in = ST_SQB;
            end
         end
         ST_SQB: begin
            mul_start  = 1'b1;
            mul_mcand  = EST_WIDTH'(leg_b_ff);
            mul_mplier = EST_WIDTH'(leg_b_ff);
            state_in   = ST_SQB_WAIT;
         end
         ST_SQB_WAIT: begin
            if (mul_done) begin
               sum_in   = sum_sat;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            sqrt_start = 1'b1;
            state_in   = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (sqrt_done) begin
               root_in  = sqrt_root;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            div_start    = 1'b1;
            div_dividend = SUM_WIDTH'(root_ff);
            div_divisor  = EST_WIDTH'(HBS_START_STEP);
            state_in     = ST_STEP_WAIT;
         end
         ST_STEP_WAIT: begin
            if (div_done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            mul_start  = 1'b1;
            mul_mcand  = EST_WIDTH'(HBS_START_STEP);
            mul_mplier = div_quotient[EST_WIDTH-1:0] + EST_WIDTH'(1);
            state_in   = ST_SCALE_WAIT;
         end
         ST_SCALE_WAIT: begin
            if (mul_done) begin
               est_in   = mul_product[EST_WIDTH-1:0];
               iter_in  = '0;
               state_in = ST_ITER;
            end
         end
         ST_ITER: begin
            if (iter_ff == iter_count_ff) begin
               state_in = ST_FIN;
            end else if (est_ff == '0) begin
               // zero estimate stays zero
               iter_in = iter_ff + HBS_ITER_WIDTH'(1);
            end else begin
               div_start = 1'b1;
               state_in  = ST_ITER_WAIT;
            end
         end
         ST_ITER_WAIT: begin
            if (div_done) begin
               est_in   = avg[EST_WIDTH:1];
               iter_in  = iter_ff + HBS_ITER_WIDTH'(1);
               state_in = ST_ITER;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hypotenuse = rsp_hyp_ff;

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER_WAIT) |-> (iter_ff < iter_count_ff))
      else $error("refinement count ran past the configured value");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (div_start && state_ff == ST_ITER) |-> (est_ff != '0))
      else $error("divider started with a zero estimate");

   a_start_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE_WAIT && mul_done) |=> (est_ff != '0))
      else $error("start estimate is zero");

   a_mul_owner: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_SQA_WAIT || state_ff == ST_SQB_WAIT ||
                    state_ff == ST_SCALE_WAIT))
      else $error("multiplier finished outside a wait state");

endmodule
